// File: rtl/mji_pkg.sv
package mji_pkg;

  // Block geometry
  localparam int unsigned JOINTS        = 4;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned LANE_BITS     = 16;
  localparam int unsigned JIDX_W        = 2;
  localparam int unsigned POS_OUT_W     = 16;

  // Configuration port
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [DUR_W-1:0] DURATION_RESET = 32'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DURATION = 2'd0,
    REG_START    = 2'd1,
    REG_TARGET   = 2'd2
  } cfg_reg_e;

  // Fixed-point widths
  localparam int unsigned Q_FRAC   = 16;
  localparam int unsigned BLEND_W  = Q_FRAC + 1;
  localparam int unsigned POLY_W   = 22;
  localparam logic [BLEND_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [POLY_W-1:0]  POLY_BASE = 22'd655360;
  localparam int unsigned DIV_BITS = 16;

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QPTR_W      = 3;
  localparam int unsigned QCNT_W      = 4;

  typedef struct packed {
    logic [DIV_BITS-1:0] quo;
    logic                fin;
  } div_res_t;

  typedef struct packed {
    logic [BLEND_W-1:0] blend;
    logic               finished;
  } q_entry_t;

endpackage

// File: rtl/mji_if.sv
interface mji_in_if;
  logic                       valid;
  logic                       ready;
  logic [mji_pkg::DUR_W-1:0]  elapsed_time;

  modport source (output valid, output elapsed_time, input ready);
  modport sink   (input valid, input elapsed_time, output ready);
endinterface

interface mji_out_if;
  logic                                valid;
  logic                                ready;
  logic [mji_pkg::JIDX_W-1:0]          joint_index;
  logic signed [mji_pkg::POS_OUT_W-1:0] joint_position;
  logic                                finished;
  logic                                last_joint;

  modport source (output valid, output joint_index, output joint_position,
                  output finished, output last_joint, input ready);
  modport sink   (input valid, input joint_index, input joint_position,
                  input finished, input last_joint, output ready);
endinterface

// File: rtl/mji_divider.sv
module mji_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [mji_pkg::DUR_W-1:0] elapsed_i,
  input  logic [mji_pkg::DUR_W-1:0] duration_i,
  output logic                      valid_o,
  output mji_pkg::div_res_t         res_o
);

  typedef struct packed {
    logic [mji_pkg::DUR_W-1:0]    rem;
    logic [mji_pkg::DIV_BITS-1:0] quo;
    logic                         fin;
  } div_stage_t;

  logic       valid_q [0:mji_pkg::DIV_BITS];
  div_stage_t stage_q [0:mji_pkg::DIV_BITS];
  logic       fin_in;

  // One restoring step: shift the remainder, subtract the divisor where it fits
  function automatic div_stage_t div_step(input div_stage_t s,
                                          input logic [mji_pkg::DUR_W-1:0] d);
    logic [mji_pkg::DUR_W:0] shifted;
    logic                    ge;
    div_stage_t              r;
    shifted = {s.rem, 1'b0};
    ge      = (shifted >= {1'b0, d});
    r       = s;
    r.rem   = ge ? mji_pkg::DUR_W'(shifted - {1'b0, d}) : shifted[mji_pkg::DUR_W-1:0];
    r.quo   = {s.quo[mji_pkg::DIV_BITS-2:0], ge};
    return r;
  endfunction

  // Phase saturates once elapsed reaches the duration (zero duration too)
  assign fin_in = (elapsed_i >= duration_i);

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= mji_pkg::DIV_BITS; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else begin
      valid_q[0] <= valid_i;
      for (int k = 0; k < mji_pkg::DIV_BITS; k++) begin
        valid_q[k+1] <= valid_q[k];
      end
    end
  end

  // Advance the partial quotients, one bit per stage
  always_ff @(posedge clk_i) begin
    stage_q[0].rem <= fin_in ? '0 : elapsed_i;
    stage_q[0].quo <= '0;
    stage_q[0].fin <= fin_in;
    for (int k = 0; k < mji_pkg::DIV_BITS; k++) begin
      stage_q[k+1] <= div_step(stage_q[k], duration_i);
    end
  end

  assign valid_o   = valid_q[mji_pkg::DIV_BITS];
  assign res_o.quo = stage_q[mji_pkg::DIV_BITS].quo;
  assign res_o.fin = stage_q[mji_pkg::DIV_BITS].fin;

endmodule

// File: rtl/mji_front.sv
module mji_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  mji_in_if.sink                    in_i,
  input  logic [mji_pkg::DUR_W-1:0] duration_i,
  input  logic                      pop_i,
  output logic                      push_o,
  output mji_pkg::q_entry_t         entry_o
);

  localparam int unsigned Q_SHIFT      = mji_pkg::Q_FRAC;
  localparam int unsigned BLEND_FULL_W = mji_pkg::BLEND_W + mji_pkg::POLY_W - Q_SHIFT;

  logic                              accept;
  logic [mji_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic                              div_valid;
  mji_pkg::div_res_t                 div_res;
  logic [mji_pkg::BLEND_W-1:0]       p_s0;
  logic [2*mji_pkg::BLEND_W-1:0]     sq_s0;
  logic [2*mji_pkg::BLEND_W-1:0]     cube_s1;
  logic [mji_pkg::POLY_W-1:0]        poly_s1;
  logic [mji_pkg::BLEND_W+mji_pkg::POLY_W-1:0] prod_s2;
  logic [BLEND_FULL_W-1:0]           blend_s2;

  logic                        v1_q, v2_q, v3_q;
  logic                        f1_q, f2_q, f3_q;
  logic [mji_pkg::BLEND_W-1:0] p1_q, p2_q1, p3_q, blend_q;
  logic [mji_pkg::POLY_W-1:0]  poly_q;

  // Accept while the queue still has a free place for every item in flight
  assign in_i.ready = (cnt_q < mji_pkg::QCNT_W'(mji_pkg::QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!accept && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  mji_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .elapsed_i  (in_i.elapsed_time),
    .duration_i (duration_i),
    .valid_o    (div_valid),
    .res_o      (div_res)
  );

  // Clamp the phase and square it
  assign p_s0  = div_res.fin ? mji_pkg::ONE_Q16 : {1'b0, div_res.quo};
  assign sq_s0 = p_s0 * p_s0;

  // Cube and the quadratic factor 10 - 15p + 6p^2
  assign cube_s1 = p2_q1 * p1_q;
  assign poly_s1 = mji_pkg::POLY_BASE + mji_pkg::POLY_W'(p2_q1) * mji_pkg::POLY_W'(6)
                 - mji_pkg::POLY_W'(p1_q) * mji_pkg::POLY_W'(15);

  // Final product, saturated at one
  assign prod_s2  = p3_q * poly_q;
  assign blend_s2 = prod_s2[mji_pkg::BLEND_W+mji_pkg::POLY_W-1:Q_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q  <= div_valid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= p_s0;
    p2_q1   <= sq_s0[mji_pkg::BLEND_W+Q_SHIFT-1:Q_SHIFT];
    f1_q    <= div_res.fin;
    p3_q    <= cube_s1[mji_pkg::BLEND_W+Q_SHIFT-1:Q_SHIFT];
    poly_q  <= poly_s1;
    f2_q    <= f1_q;
    blend_q <= (blend_s2 > BLEND_FULL_W'(mji_pkg::ONE_Q16)) ? mji_pkg::ONE_Q16
             : blend_s2[mji_pkg::BLEND_W-1:0];
    f3_q    <= f2_q;
  end

  assign push_o           = v3_q;
  assign entry_o.blend    = blend_q;
  assign entry_o.finished = f3_q;

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mji_pkg::QCNT_W'(mji_pkg::QUEUE_DEPTH))
    else $error("front: in-flight count beyond queue depth");

endmodule

// File: rtl/mji_queue.sv
module mji_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mji_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output logic              empty_o,
  output mji_pkg::q_entry_t head_o
);

  mji_pkg::q_entry_t          mem_q [mji_pkg::QUEUE_DEPTH];
  logic [mji_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [mji_pkg::QCNT_W-1:0] cnt_q;
  logic                       full;

  assign empty_o = (cnt_q == '0);
  assign full    = (cnt_q == mji_pkg::QCNT_W'(mji_pkg::QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full))
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue: pop while empty");

endmodule

// File: rtl/mji_back.sv
module mji_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  mji_pkg::q_entry_t         head_i,
  input  logic [mji_pkg::CFG_W-1:0] start_i,
  input  logic [mji_pkg::CFG_W-1:0] target_i,
  output logic                      pop_o,
  mji_out_if.source                 out_o
);

  localparam int unsigned PROD_W = mji_pkg::POSITION_BITS + 1 + mji_pkg::BLEND_W + 1;

  logic [mji_pkg::JIDX_W-1:0]               joint_q;
  logic                                     load, issue, last;
  logic signed [mji_pkg::POSITION_BITS-1:0] s_pos, t_pos, new_pos;
  logic signed [mji_pkg::POSITION_BITS:0]   diff;
  logic signed [mji_pkg::BLEND_W:0]         blend_s;
  logic signed [PROD_W-1:0]                 prod, sum;

  logic                                 valid_q;
  logic [mji_pkg::JIDX_W-1:0]           idx_q;
  logic signed [mji_pkg::POS_OUT_W-1:0] pos_q;
  logic                                 fin_q, last_q;

  // Issue a joint whenever the output register is free and a word waits
  assign load  = !valid_q || out_o.ready;
  assign issue = load && !empty_i;
  assign last  = (joint_q == mji_pkg::JIDX_W'(mji_pkg::JOINTS - 1));
  assign pop_o = issue && last;

  // Pick the lanes of the current joint
  assign s_pos = start_i[{joint_q, 4'b0000} +: mji_pkg::POSITION_BITS];
  assign t_pos = target_i[{joint_q, 4'b0000} +: mji_pkg::POSITION_BITS];

  // start + floor((target - start) * blend / 2^16)
  assign diff    = (mji_pkg::POSITION_BITS+1)'(t_pos) - (mji_pkg::POSITION_BITS+1)'(s_pos);
  assign blend_s = $signed({1'b0, head_i.blend});
  assign prod    = PROD_W'(diff) * PROD_W'(blend_s);
  assign sum     = PROD_W'(s_pos) + (prod >>> mji_pkg::Q_FRAC);
  assign new_pos = sum[mji_pkg::POSITION_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (issue) begin
        joint_q <= last ? '0 : joint_q + 1'b1;
      end
      if (load) begin
        valid_q <= !empty_i;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (issue) begin
      idx_q  <= joint_q;
      pos_q  <= mji_pkg::POS_OUT_W'(new_pos);
      fin_q  <= head_i.finished;
      last_q <= last;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.joint_index    = idx_q;
  assign out_o.joint_position = pos_q;
  assign out_o.finished       = fin_q;
  assign out_o.last_joint     = last_q;

  a_joint_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_joint) |=>
      (out_o.valid &&
       out_o.joint_index == mji_pkg::JIDX_W'($past(out_o.joint_index) + 1'b1)))
    else $error("back: joints of one word not delivered in sequence");

endmodule

// File: rtl/min_jerk_joint_interpolator.sv
// An accepted word passes the phase divider, the blend registers and the queue
// to the output register, its remaining joints following on consecutive cycles
// while the sink is ready. Sustained input is bounded by the single result
// channel; the 16-stage phase divider and blend pipeline accept every cycle
// while the queue has room. Up to 8 words may be in flight between input and
// queue head. Reset: duration 1000, positions 0, pipeline and queue empty.
module min_jerk_joint_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mji_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mji_pkg::CFG_W-1:0]     cfg_data_i,
  mji_in_if.sink                        in_i,
  mji_out_if.source                     out_o
);

  logic [mji_pkg::DUR_W-1:0] duration_q;
  logic [mji_pkg::CFG_W-1:0] start_q, target_q;
  logic                      push, pop, empty;
  mji_pkg::q_entry_t         entry, head;

  // Write the configuration registers; unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q <= mji_pkg::DURATION_RESET;
      start_q    <= '0;
      target_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (mji_pkg::cfg_reg_e'(cfg_idx_i))
        mji_pkg::REG_DURATION: duration_q <= cfg_data_i[mji_pkg::DUR_W-1:0];
        mji_pkg::REG_START:    start_q    <= cfg_data_i;
        mji_pkg::REG_TARGET:   target_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mji_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .duration_i (duration_q),
    .pop_i      (pop),
    .push_o     (push),
    .entry_o    (entry)
  );

  mji_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  mji_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head),
    .start_i  (start_q),
    .target_i (target_q),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
